FILE: sv/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants for the chained hash table engine
// Sizes, command and status codes, channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package chte_pkg;
    localparam int MAX_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int BKT_W  = $clog2(MAX_BUCKETS);
    localparam int NODE_W = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam int CNT_W  = 9;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_ENTRIES);
    localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(256);

    localparam logic [1:0] CMD_ENTER   = 2'd0;
    localparam logic [1:0] CMD_FIND    = 2'd1;
    localparam logic [1:0] CMD_EXTRACT = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXTRACTED = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic [31:0]        data_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_out;
    } rsp_t;
endpackage
`default_nettype wire

FILE: sv/chte_if.sv
// ----------------------------------------------------------------------------
// chte_req_if / chte_rsp_if: valid-ready channels
// One transfer when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none
interface chte_req_if;
    logic valid;
    logic ready;
    chte_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chte_rsp_if;
    logic valid;
    logic ready;
    chte_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/chte_mod.sv
// ----------------------------------------------------------------------------
// chte_mod: bucket index unit
// Magnitude of the key modulo the bucket count, restoring, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module chte_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [31:0]                 mag,
    input  wire logic [chte_pkg::CNT_W-1:0]  divisor,
    output logic                             done,
    output logic [chte_pkg::BKT_W-1:0]       rem
);
    import chte_pkg::*;

    logic [31:0]      q_reg;
    logic [CNT_W:0]   r_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic [CNT_W:0]   shifted;
    logic [CNT_W:0]   d_ext;

    assign d_ext   = {1'b0, divisor};
    assign shifted = {r_reg[CNT_W-1:0], q_reg[31]};
    assign done    = busy_reg && (cnt_reg == 6'd0);
    assign rem     = r_reg[BKT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= mag;
            r_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            q_reg <= {q_reg[30:0], 1'b0};
            r_reg <= (shifted >= d_ext) ? shifted - d_ext : shifted;
        end
    end
endmodule
`default_nettype wire

FILE: sv/chained_hash_table_engine_top.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top: hash table with separate chaining
// Integer keys, enter / find / extract over a fixed node pool.
// ----------------------------------------------------------------------------
// Requests arrive on req (cmd, key, data_in); one response per request leaves
// on rsp (status, data_out). bucket_count is written through cfg_we/cfg_data
// while the engine is idle, a rule the user must keep, since the block does
// not enforce it; zero acts as one, values above 256 as 256. One request is
// walked at a time. After the transfer the bucket modulo runs (one remainder
// bit a cycle), then the head is read, then every chain slot visited is read
// from the synchronous node memory and then compared, the end of the chain
// included. An insert then pops the free list. req.ready rises with rsp.valid,
// so a new request is taken only after the previous walk has finished.
// After reset a clearing pass over all 1024 pool entries builds the free
// list in the link memory; bucket heads are cleared by per-bucket valid bits
// at once. No request is accepted during the pass.
// The response is held in an output register until taken; while it waits the
// next request is accepted and starts its modulo, but does not touch the
// tables until the response has gone.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_table_engine_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [chte_pkg::CNT_W-1:0] cfg_data,
    chte_req_if.sink                        req,
    chte_rsp_if.source                      rsp
);
    import chte_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_HRD   = 4'd8;

    logic [3:0]        state_reg;
    logic [CNT_W-1:0]  bcnt_reg;
    logic [CNT_W-1:0]  div_eff;
    logic [NODE_W:0]   init_reg;
    logic [LINK_W-1:0] free_reg;

    logic [LINK_W-1:0] head_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] head_vld_reg;
    logic [31:0]       key_mem  [POOL_ENTRIES];
    logic [31:0]       val_mem  [POOL_ENTRIES];
    logic [LINK_W-1:0] link_mem [POOL_ENTRIES];

    logic [1:0]        cmd_reg;
    logic [31:0]       key_reg;
    logic [31:0]       din_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LINK_W-1:0] cur_reg;
    logic [LINK_W-1:0] prev_reg;
    logic [NODE_W:0]   steps_reg;
    logic [LINK_W-1:0] head_rd_reg;
    logic [31:0]       key_rd_reg;
    logic [31:0]       val_rd_reg;
    logic [LINK_W-1:0] link_rd_reg;
    logic              rsp_vld_reg;
    rsp_t              rsp_reg;

    logic [31:0]       mag;
    logic              mod_start;
    logic              mod_done;
    logic [BKT_W-1:0]  mod_rem;
    logic              mod_fin_reg;
    logic [BKT_W-1:0]  rem_reg;
    logic              req_xfer;
    logic              cur_ok;
    logic              ext_pend_reg;
    logic [LINK_W-1:0] ext_free_reg;

    assign div_eff = (bcnt_reg == '0) ? CNT_W'(1) :
                     (bcnt_reg > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) : bcnt_reg;
    assign mag = req.data.key[31] ? (32'd0 - req.data.key) : req.data.key;
    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer = req.valid && req.ready;
    assign mod_start = req_xfer;
    assign rsp.valid = rsp_vld_reg;
    assign rsp.data = rsp_reg;
    assign cur_ok = (cur_reg < LINK_W'(POOL_ENTRIES)) && (steps_reg < (NODE_W+1)'(POOL_ENTRIES));

    chte_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .mag(mag),
        .divisor(div_eff), .done(mod_done), .rem(mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcnt_reg <= CNT_RESET;
        else if (cfg_we)
            bcnt_reg <= cfg_data;
    end

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        head_rd_reg <= head_vld_reg[bkt_reg] ? head_mem[bkt_reg] : LINK_NONE;
        key_rd_reg  <= key_mem[cur_reg[NODE_W-1:0]];
        val_rd_reg  <= val_mem[cur_reg[NODE_W-1:0]];
        link_rd_reg <= link_mem[(state_reg == S_FREE) ? free_reg[NODE_W-1:0]
                                                      : cur_reg[NODE_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_fin_reg <= 1'b0;
        else if (req_xfer)
            mod_fin_reg <= 1'b0;
        else if (mod_done)
            mod_fin_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_reg     <= '0;
            free_reg     <= '0;
            head_vld_reg <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rsp_vld_reg && rsp.ready)
                rsp_vld_reg <= 1'b0;
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == (NODE_W+1)'(POOL_ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_xfer)
                        state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    // wait for the index and for the previous response to drain
                    if ((mod_fin_reg || mod_done) && !rsp_vld_reg)
                        state_reg <= S_HEAD;
                end
                S_HEAD:
                    state_reg <= S_HRD;
                S_HRD:
                    state_reg <= S_RD;
                S_RD:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (!cur_ok)
                    begin
                        if (cmd_reg == CMD_ENTER && free_reg != LINK_NONE)
                        begin
                            if (prev_reg == LINK_NONE)
                                head_vld_reg[bkt_reg] <= 1'b1;
                            state_reg <= S_FREE;
                        end
                        else
                        begin
                            rsp_vld_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end
                    else if (key_rd_reg == key_reg)
                    begin
                        rsp_vld_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        if (cmd_reg == CMD_EXTRACT)
                        begin
                            free_reg <= cur_reg;
                            if (prev_reg == LINK_NONE)
                                head_vld_reg[bkt_reg] <= 1'b1;
                        end
                    end
                    else
                        state_reg <= S_RD;
                end
                S_FREE:
                    state_reg <= S_FRD;
                S_FRD:
                begin
                    free_reg    <= link_rd_reg;
                    rsp_vld_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath and memory writes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
            link_mem[init_reg[NODE_W-1:0]] <= LINK_W'(init_reg + 1'b1);
        if (req_xfer)
        begin
            cmd_reg <= req.data.cmd;
            key_reg <= req.data.key;
            din_reg <= req.data.data_in;
        end
        if (mod_done)
            rem_reg <= mod_rem;
        unique case (state_reg)
            S_MOD:
                bkt_reg <= mod_done ? mod_rem : rem_reg;
            S_HEAD:
            begin
                prev_reg  <= LINK_NONE;
                steps_reg <= '0;
            end
            S_HRD:
                cur_reg <= head_rd_reg;
            S_CMP:
            begin
                if (!cur_ok)
                begin
                    if (cmd_reg == CMD_ENTER && free_reg != LINK_NONE)
                    begin
                        key_mem[free_reg[NODE_W-1:0]]  <= key_reg;
                        val_mem[free_reg[NODE_W-1:0]]  <= din_reg;
                        if (prev_reg == LINK_NONE)
                            head_mem[bkt_reg] <= free_reg;
                        else
                            link_mem[prev_reg[NODE_W-1:0]] <= free_reg;
                        rsp_reg <= '{status: ST_INSERTED, data_out: 32'd0};
                    end
                    else
                        rsp_reg <= '{status: (cmd_reg == CMD_ENTER) ? ST_FULL : ST_NOT_FOUND,
                                     data_out: 32'd0};
                end
                else if (key_rd_reg == key_reg)
                begin
                    unique case (cmd_reg)
                        CMD_ENTER:
                        begin
                            val_mem[cur_reg[NODE_W-1:0]] <= din_reg;
                            rsp_reg <= '{status: ST_REPLACED, data_out: 32'd0};
                        end
                        CMD_FIND:
                            rsp_reg <= '{status: ST_FOUND, data_out: val_rd_reg};
                        CMD_EXTRACT:
                        begin
                            if (prev_reg == LINK_NONE)
                                head_mem[bkt_reg] <= link_rd_reg;
                            else
                                link_mem[prev_reg[NODE_W-1:0]] <= link_rd_reg;
                            rsp_reg <= '{status: ST_EXTRACTED, data_out: val_rd_reg};
                        end
                        default:
                            rsp_reg <= '{status: ST_NOT_FOUND, data_out: 32'd0};
                    endcase
                end
                else
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= link_rd_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
            end
            S_FRD:
                link_mem[free_reg[NODE_W-1:0]] <= LINK_NONE;
            default:
            begin
            end
        endcase
        // extracted node links to the old free head in the cycle after the unlink
        if (ext_pend_reg)
            link_mem[free_reg[NODE_W-1:0]] <= ext_free_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ext_pend_reg <= 1'b0;
        else
            ext_pend_reg <= (state_reg == S_CMP) && cur_ok && (key_rd_reg == key_reg)
                            && (cmd_reg == CMD_EXTRACT);
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CMP) && cur_ok)
            ext_free_reg <= free_reg;
    end

    property p_no_req_in_init;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_INIT) |-> !req.ready;
    endproperty
    a_no_req_in_init: assert property (p_no_req_in_init) else $error("ready during init");

    property p_rsp_hold;
        @(posedge clk) disable iff (!rst_n) (rsp.valid && !rsp.ready) |=> rsp.valid;
    endproperty
    a_rsp_hold: assert property (p_rsp_hold) else $error("response dropped");

    property p_walk_waits_rsp;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_HEAD) |-> !rsp_vld_reg;
    endproperty
    a_walk_waits_rsp: assert property (p_walk_waits_rsp) else $error("walk with rsp pending");
endmodule
`default_nettype wire
